@@ hdl/bsr_pkg.sv @@
// Shared types and codes for the byte stream reassembler.
`default_nettype none

package bsr_pkg;

    // Operation codes on the input op field.
    localparam logic [1:0] OP_BYTE     = 2'd0;
    localparam logic [1:0] OP_END_MARK = 2'd1;
    localparam logic [1:0] OP_POP      = 2'd2;

    localparam logic [31:0] INDEX_MAX  = 32'hFFFF_FFFF;
    localparam int          WAIT_OUT_W = 11;

    typedef enum logic [1:0] {
        K_ARRIVE,
        K_END_MARK,
        K_POP,
        K_NOP
    } t_kind;

    // Decoded command handed from the front end to the engine.
    typedef struct packed {
        t_kind       kind;
        logic [31:0] index;
        logic [7:0]  value;
        logic        end_set;
        logic [31:0] end_len;
    } t_cmd;

    typedef struct packed {
        logic [7:0]            read_byte;
        logic                  read_valid;
        logic                  accepted;
        logic [31:0]           written_count;
        logic [WAIT_OUT_W-1:0] waiting_count;
        logic                  stream_ended;
    } t_result;

    // One slot of the window store.
    typedef struct packed {
        logic       present;
        logic [7:0] data;
    } t_entry;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_INS_ADDR,
        S_INS_CHK,
        S_DRAIN_RD,
        S_DRAIN_CHK,
        S_POP_WAIT,
        S_FIN_CHK,
        S_EMIT
    } t_back_state;

endpackage

`default_nettype wire

@@ hdl/byte_stream_reassembler.sv @@
// Top level of the byte stream reassembler.
`default_nettype none

// Reorders stream bytes that arrive out of order inside a window of CAPACITY
// bytes and hands back one result per input transfer, in input order. After
// reset the block sweeps its window store once, one slot per cycle, and holds
// full high for the whole sweep. A two-entry command queue sits between
// the input decoder and the engine, and a two-entry result queue on the
// output, so either side may stall on its own. The engine works on one item
// at a time over a store with one read and one write port: a pop reads one
// slot, an end mark or a byte outside the window goes straight to the end
// check, and an accepted byte reads its slot, fills it if empty, then drains
// the bytes it makes contiguous (each costs one store read and one write-back).
module byte_stream_reassembler #(
    parameter int CAPACITY = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_stream_index,
    input  logic [7:0]  i_byte_value,
    input  logic        i_ends_stream,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_read_byte,
    output logic        o_read_valid,
    output logic        o_accepted,
    output logic [31:0] o_written_count,
    output logic [10:0] o_waiting_count,
    output logic        o_stream_ended
);

    import bsr_pkg::*;

    t_cmd    cmd;
    logic    cmd_valid;
    logic    cmd_take;
    logic    clearing;
    t_result res_in;
    t_result res_out;
    logic    res_push;
    logic    res_full;

    bsr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_op           (i_op),
        .i_stream_index (i_stream_index),
        .i_byte_value   (i_byte_value),
        .i_ends_stream  (i_ends_stream),
        .i_hold         (clearing),
        .o_full         (full),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd),
        .i_cmd_take     (cmd_take)
    );

    bsr_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_clearing  (clearing),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_full  (res_full)
    );

    bsr_result_q u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res_in),
        .o_full  (res_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (res_out)
    );

    assign o_read_byte     = res_out.read_byte;
    assign o_read_valid    = res_out.read_valid;
    assign o_accepted      = res_out.accepted;
    assign o_written_count = res_out.written_count;
    assign o_waiting_count = res_out.waiting_count;
    assign o_stream_ended  = res_out.stream_ended;

`ifndef NO_ASSERTIONS
    // The store sweep must hold off input right after reset.
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> full)
        else $error("input not held off during store sweep");

    // A pop never also reports an accepted byte.
    a_pop_not_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !(o_read_valid && o_accepted))
        else $error("result reports both a read and an accepted byte");

    // Waiting bytes can never exceed the window.
    a_waiting_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ({21'd0, o_waiting_count} <= 32'(CAPACITY)))
        else $error("waiting count exceeds capacity");
`endif

endmodule

`default_nettype wire

@@ hdl/bsr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bsr_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hdl/bsr_front.sv @@
// Front end: accepts input transfers, decodes them and queues the commands.
`default_nettype none

module bsr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [1:0]    i_op,
    input  logic [31:0]   i_stream_index,
    input  logic [7:0]    i_byte_value,
    input  logic          i_ends_stream,
    input  logic          i_hold,
    output logic          o_full,
    output logic          o_cmd_valid,
    output bsr_pkg::t_cmd o_cmd,
    input  logic          i_cmd_take
);

    import bsr_pkg::*;

    t_cmd       dec_cmd;
    t_cmd       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       push_ok;
    logic       take_ok;

    always_comb begin
        dec_cmd.index   = i_stream_index;
        dec_cmd.value   = i_byte_value;
        dec_cmd.end_len = i_stream_index + 32'd1;
        dec_cmd.end_set = 1'b0;
        unique case (i_op)
            OP_BYTE: begin
                dec_cmd.kind    = K_ARRIVE;
                // A final byte at the top index has a length that cannot be held.
                dec_cmd.end_set = i_ends_stream && (i_stream_index != INDEX_MAX);
            end
            OP_END_MARK: dec_cmd.kind = K_END_MARK;
            OP_POP:      dec_cmd.kind = K_POP;
            default:     dec_cmd.kind = K_NOP;
        endcase
    end

    assign o_full      = (r_count == 2'd2) || i_hold;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd];
    assign push_ok     = i_push && !o_full;
    assign take_ok     = i_cmd_take && o_cmd_valid;

    always_comb begin
        n_count = r_count;
        if (push_ok && !take_ok) begin
            n_count = r_count + 2'd1;
        end else if (!push_ok && take_ok) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wr <= ~r_wr;
            end
            if (take_ok) begin
                r_rd <= ~r_rd;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr] <= dec_cmd;
        end
    end

endmodule

`default_nettype wire

@@ hdl/bsr_back.sv @@
// Engine: carries out commands against the window store and builds results.
`default_nettype none

module bsr_back #(
    parameter int CAPACITY = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  bsr_pkg::t_cmd    i_cmd,
    output logic             o_cmd_take,
    output logic             o_clearing,
    output logic             o_res_push,
    output bsr_pkg::t_result o_res,
    input  logic             i_res_full
);

    import bsr_pkg::*;

    localparam int              AW        = $clog2(CAPACITY);
    localparam int              WAIT_W    = $clog2(CAPACITY + 1);
    localparam int              EW        = $bits(t_entry);
    localparam logic [AW:0]     CAP_EXT   = (AW + 1)'(CAPACITY);
    localparam logic [AW-1:0]   SLOT_LAST = AW'(CAPACITY - 1);
    localparam logic [32:0]     CAP_33    = 33'(CAPACITY);
    localparam logic [32:0]     LIM_MAX   = 33'h0_FFFF_FFFF;

    t_back_state r_state, n_state;

    logic [31:0]       r_wp, n_wp;
    logic [31:0]       r_rp, n_rp;
    logic [AW-1:0]     r_wp_slot, n_wp_slot;
    logic [AW-1:0]     r_rp_slot, n_rp_slot;
    logic [WAIT_W-1:0] r_wait, n_wait;
    logic              r_end_known, n_end_known;
    logic [31:0]       r_end_pos, n_end_pos;
    logic              r_fin, n_fin;
    logic [AW-1:0]     r_clr, n_clr;

    t_cmd              r_cmd, n_cmd;
    logic              r_acc, n_acc;
    logic              r_rvalid, n_rvalid;
    logic [7:0]        r_rbyte, n_rbyte;
    logic [AW-1:0]     r_slot, n_slot;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [EW-1:0]     ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [EW-1:0]     ram_rdata;
    t_entry            rd_entry;
    t_entry            wr_entry;

    logic [32:0]       lim_sum;
    logic [32:0]       lim;
    logic              idx_in_win;
    logic              wp_below_lim;
    logic              can_pop;
    logic [31:0]       offset;
    logic [AW:0]       slot_sum;
    logic [AW-1:0]     slot_calc;
    logic [AW-1:0]     wp_slot_inc;
    logic [AW-1:0]     rp_slot_inc;
    logic              fin_hit;

    bsr_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry  = t_entry'(ram_rdata);
    assign ram_wdata = EW'(wr_entry);

    // The window ends at read point plus capacity, held below the top index.
    assign lim_sum      = {1'b0, r_rp} + CAP_33;
    assign lim          = (lim_sum > LIM_MAX) ? LIM_MAX : lim_sum;
    assign idx_in_win   = ({1'b0, i_cmd.index} >= {1'b0, r_wp})
                       && ({1'b0, i_cmd.index} < lim);
    assign wp_below_lim = ({1'b0, r_wp} < lim);
    assign can_pop      = (r_rp < r_wp);

    // An index in the window lies less than one capacity past the read point,
    // so its slot is the read slot plus that distance, wrapped once.
    assign offset    = r_cmd.index - r_rp;
    assign slot_sum  = {1'b0, r_rp_slot} + {1'b0, offset[AW-1:0]};
    assign slot_calc = (slot_sum >= CAP_EXT) ? AW'(slot_sum - CAP_EXT) : slot_sum[AW-1:0];

    assign wp_slot_inc = (r_wp_slot == SLOT_LAST) ? '0 : r_wp_slot + AW'(1);
    assign rp_slot_inc = (r_rp_slot == SLOT_LAST) ? '0 : r_rp_slot + AW'(1);
    assign fin_hit     = r_end_known && (r_wp == r_end_pos);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == SLOT_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.kind)
                        K_POP:      n_state = can_pop ? S_POP_WAIT : S_EMIT;
                        K_ARRIVE: begin
                            if (r_fin) begin
                                n_state = S_EMIT;
                            end else if (idx_in_win) begin
                                n_state = S_INS_ADDR;
                            end else begin
                                n_state = S_FIN_CHK;
                            end
                        end
                        K_END_MARK: n_state = r_fin ? S_EMIT : S_FIN_CHK;
                        default:    n_state = S_EMIT;
                    endcase
                end
            end
            S_INS_ADDR:  n_state = S_INS_CHK;
            S_INS_CHK:   n_state = S_DRAIN_RD;
            S_DRAIN_RD:  n_state = wp_below_lim ? S_DRAIN_CHK : S_FIN_CHK;
            S_DRAIN_CHK: n_state = rd_entry.present ? S_DRAIN_RD : S_FIN_CHK;
            S_POP_WAIT:  n_state = S_EMIT;
            S_FIN_CHK:   n_state = S_EMIT;
            S_EMIT: begin
                if (!i_res_full) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // Outputs: store access and handshakes.
    always_comb begin
        ram_we     = 1'b0;
        ram_waddr  = r_clr;
        wr_entry   = '0;
        ram_re     = 1'b0;
        ram_raddr  = r_wp_slot;
        o_cmd_take = 1'b0;
        o_res_push = 1'b0;
        o_clearing = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_clearing = 1'b1;
                ram_we     = 1'b1;
                ram_waddr  = r_clr;
            end
            S_IDLE: begin
                o_cmd_take = i_cmd_valid;
                if (i_cmd_valid && (i_cmd.kind == K_POP) && can_pop) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_rp_slot;
                end
            end
            S_INS_ADDR: begin
                ram_re    = 1'b1;
                ram_raddr = slot_calc;
            end
            S_INS_CHK: begin
                // The byte stored first wins, so a present slot is left alone.
                if (!rd_entry.present) begin
                    ram_we           = 1'b1;
                    ram_waddr        = r_slot;
                    wr_entry.present = 1'b1;
                    wr_entry.data    = r_cmd.value;
                end
            end
            S_DRAIN_RD: begin
                if (wp_below_lim) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_wp_slot;
                end
            end
            S_DRAIN_CHK: begin
                if (rd_entry.present) begin
                    ram_we           = 1'b1;
                    ram_waddr        = r_wp_slot;
                    wr_entry.present = 1'b0;
                    wr_entry.data    = rd_entry.data;
                end
            end
            S_EMIT: o_res_push = !i_res_full;
            default: begin
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_wp_slot   = r_wp_slot;
        n_rp_slot   = r_rp_slot;
        n_wait      = r_wait;
        n_end_known = r_end_known;
        n_end_pos   = r_end_pos;
        n_fin       = r_fin;
        n_clr       = r_clr;
        n_cmd       = r_cmd;
        n_acc       = r_acc;
        n_rvalid    = r_rvalid;
        n_rbyte     = r_rbyte;
        n_slot      = r_slot;
        unique case (r_state)
            S_CLEAR: n_clr = r_clr + AW'(1);
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd    = i_cmd;
                    n_acc    = 1'b0;
                    n_rvalid = 1'b0;
                    n_rbyte  = 8'd0;
                    if (!r_fin) begin
                        unique case (i_cmd.kind)
                            K_ARRIVE: begin
                                if (i_cmd.end_set) begin
                                    n_end_known = 1'b1;
                                    n_end_pos   = i_cmd.end_len;
                                end
                                n_acc = idx_in_win;
                            end
                            K_END_MARK: begin
                                n_end_known = 1'b1;
                                n_end_pos   = i_cmd.index;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            S_INS_ADDR: n_slot = slot_calc;
            S_INS_CHK: begin
                if (!rd_entry.present) begin
                    n_wait = r_wait + WAIT_W'(1);
                end
            end
            S_DRAIN_CHK: begin
                if (rd_entry.present) begin
                    n_wait    = (r_wait != '0) ? r_wait - WAIT_W'(1) : r_wait;
                    n_wp      = r_wp + 32'd1;
                    n_wp_slot = wp_slot_inc;
                end
            end
            S_POP_WAIT: begin
                n_rbyte   = rd_entry.data;
                n_rvalid  = 1'b1;
                n_rp      = r_rp + 32'd1;
                n_rp_slot = rp_slot_inc;
            end
            S_FIN_CHK: begin
                if (fin_hit) begin
                    n_fin = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_wp        <= 32'd0;
            r_rp        <= 32'd0;
            r_wp_slot   <= '0;
            r_rp_slot   <= '0;
            r_wait      <= '0;
            r_end_known <= 1'b0;
            r_end_pos   <= 32'd0;
            r_fin       <= 1'b0;
            r_clr       <= '0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_wp_slot   <= n_wp_slot;
            r_rp_slot   <= n_rp_slot;
            r_wait      <= n_wait;
            r_end_known <= n_end_known;
            r_end_pos   <= n_end_pos;
            r_fin       <= n_fin;
            r_clr       <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_acc    <= n_acc;
        r_rvalid <= n_rvalid;
        r_rbyte  <= n_rbyte;
        r_slot   <= n_slot;
    end

    always_comb begin
        o_res.read_byte     = r_rbyte;
        o_res.read_valid    = r_rvalid;
        o_res.accepted      = r_acc;
        o_res.written_count = r_wp;
        o_res.waiting_count = WAIT_OUT_W'(r_wait);
        o_res.stream_ended  = r_fin;
    end

endmodule

`default_nettype wire

@@ hdl/bsr_result_q.sv @@
// Two-entry result queue that feeds the output side.
`default_nettype none

module bsr_result_q (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bsr_pkg::t_result i_res,
    output logic             o_full,
    output logic             o_empty,
    input  logic             i_pop,
    output bsr_pkg::t_result o_res
);

    import bsr_pkg::*;

    t_result    r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       push_ok;
    logic       pop_ok;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_res   = r_q[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_count = r_count;
        if (push_ok && !pop_ok) begin
            n_count = r_count + 2'd1;
        end else if (!push_ok && pop_ok) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wr <= ~r_wr;
            end
            if (pop_ok) begin
                r_rd <= ~r_rd;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr] <= i_res;
        end
    end

endmodule

`default_nettype wire

@@ bench/byte_stream_reassembler_test.sv @@
// Self-checking testbench for the byte stream reassembler.
module byte_stream_reassembler_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bsr_pkg::*;

    localparam int          CAP         = 1024;
    localparam int          CYCLE_LIMIT = 400_000;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    // End positions are kept at least this far from the write point so that
    // the stream cannot end before the closing sequence.
    localparam logic [31:0] END_GUARD   = 32'd8192;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] idx;
        logic [7:0]  val;
        logic        last;
        logic        typed;
        t_result     want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic [1:0]  i_op = OP_BYTE;
    logic [31:0] i_stream_index = '0;
    logic [7:0]  i_byte_value = '0;
    logic        i_ends_stream = 1'b0;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    logic [7:0]  o_read_byte;
    logic        o_read_valid;
    logic        o_accepted;
    logic [31:0] o_written_count;
    logic [10:0] o_waiting_count;
    logic        o_stream_ended;

    byte_stream_reassembler #(.CAPACITY(CAP)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_op            (i_op),
        .i_stream_index  (i_stream_index),
        .i_byte_value    (i_byte_value),
        .i_ends_stream   (i_ends_stream),
        .empty           (empty),
        .pop             (pop),
        .o_read_byte     (o_read_byte),
        .o_read_valid    (o_read_valid),
        .o_accepted      (o_accepted),
        .o_written_count (o_written_count),
        .o_waiting_count (o_waiting_count),
        .o_stream_ended  (o_stream_ended)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predicted window state.
    logic [7:0]            win_bytes [CAP];
    bit                    win_present [CAP];
    logic [31:0]           wr_ptr = '0;
    logic [31:0]           rd_ptr = '0;
    logic [WAIT_OUT_W-1:0] waiting = '0;
    bit                    end_known = 1'b0;
    logic [31:0]           end_pos = '0;
    bit                    done = 1'b0;

    t_result pending_reports[$];
    t_row    directed_rows[$];
    int      errors = 0;
    int      cycle_count = 0;
    bit      tx_quiet = 1'b0;
    bit      rx_quiet = 1'b0;
    int      rx_wait = 0;
    t_result want;
    t_result seen;

    function automatic t_result reassemble_step(input logic [1:0] op, input logic [31:0] idx,
                                                input logic [7:0] val, input logic last);
        t_result     r;
        logic [32:0] lim;
        int          slot;
        r = '0;
        lim = {1'b0, rd_ptr} + 33'(CAP);
        if (lim > 33'h0_FFFF_FFFF) begin
            lim = 33'h0_FFFF_FFFF;
        end
        if (op == OP_POP) begin
            if (rd_ptr < wr_ptr) begin
                r.read_byte = win_bytes[rd_ptr % CAP];
                r.read_valid = 1'b1;
                rd_ptr++;
            end
        end else if ((op == OP_BYTE || op == OP_END_MARK) && !done) begin
            if (op == OP_END_MARK) begin
                end_known = 1'b1;
                end_pos = idx;
            end else begin
                // A final byte at the top index cannot carry a length.
                if (last && idx != INDEX_MAX) begin
                    end_known = 1'b1;
                    end_pos = idx + 32'd1;
                end
                if (idx >= wr_ptr && {1'b0, idx} < lim) begin
                    slot = idx % CAP;
                    r.accepted = 1'b1;
                    if (!win_present[slot]) begin
                        win_present[slot] = 1'b1;
                        win_bytes[slot] = val;
                        waiting++;
                    end
                    while ({1'b0, wr_ptr} < lim && win_present[wr_ptr % CAP]) begin
                        win_present[wr_ptr % CAP] = 1'b0;
                        if (waiting > 0) begin
                            waiting--;
                        end
                        wr_ptr++;
                    end
                end
            end
            if (end_known && wr_ptr == end_pos) begin
                done = 1'b1;
            end
        end
        r.written_count = wr_ptr;
        r.waiting_count = waiting;
        r.stream_ended = done;
        return r;
    endfunction

    function automatic t_result report_of(input logic [7:0] rb, input int rv, input int acc,
                                          input int wc, input int wt, input int fin);
        return {rb, 1'(rv), 1'(acc), 32'(wc), WAIT_OUT_W'(wt), 1'(fin)};
    endfunction

    function automatic logic [31:0] clear_of_write_point(input logic [31:0] v);
        if (v - wr_ptr < END_GUARD) begin
            return v + END_GUARD;
        end
        return v;
    endfunction

    task automatic add_row(input logic [1:0] op, input logic [31:0] idx, input logic [7:0] val,
                           input logic last, input logic typed, input t_result want_row);
        directed_rows.push_back({op, idx, val, last, typed, want_row});
    endtask

    // Offers one item and waits for its transfer; the prediction is taken at
    // the edge where the item is accepted.
    task automatic send_item(input logic [1:0] op, input logic [31:0] idx, input logic [7:0] val,
                             input logic last, input logic typed, input t_result want_row);
        int      gap;
        t_result got;
        if ($urandom_range(0, 31) == 0) begin
            tx_quiet = !tx_quiet;
        end
        gap = tx_quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_op <= op;
        i_stream_index <= idx;
        i_byte_value <= val;
        i_ends_stream <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        got = reassemble_step(op, idx, val, last);
        pending_reports.push_back(typed ? want_row : got);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: check every transfer and draw the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            seen = {o_read_byte, o_read_valid, o_accepted, o_written_count, o_waiting_count,
                    o_stream_ended};
            if (pending_reports.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected result: byte=%h vld=%b acc=%b wr=%0d wt=%0d end=%b",
                             seen.read_byte, seen.read_valid, seen.accepted,
                             seen.written_count, seen.waiting_count, seen.stream_ended);
                end
            end else begin
                want = pending_reports.pop_front();
                if (seen.read_byte !== want.read_byte || seen.read_valid !== want.read_valid ||
                    seen.accepted !== want.accepted ||
                    seen.written_count !== want.written_count ||
                    seen.waiting_count !== want.waiting_count ||
                    seen.stream_ended !== want.stream_ended) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch: want byte=%h vld=%b acc=%b wr=%0d wt=%0d end=%b",
                                 want.read_byte, want.read_valid, want.accepted,
                                 want.written_count, want.waiting_count, want.stream_ended);
                        $display("          got  byte=%h vld=%b acc=%b wr=%0d wt=%0d end=%b",
                                 seen.read_byte, seen.read_valid, seen.accepted,
                                 seen.written_count, seen.waiting_count, seen.stream_ended);
                    end
                end
            end
            if ($urandom_range(0, 31) == 0) begin
                rx_quiet = !rx_quiet;
            end
            rx_wait = rx_quiet ? 0 : $urandom_range(0, 11);
            if (rx_wait != 0) begin
                pop <= 1'b0;
            end
        end else if (!pop) begin
            if (rx_wait > 1) begin
                rx_wait--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        int          n;
        int          pop_pct;
        int          r;
        int          j;
        bit          paused;
        logic [31:0] idx;
        logic [31:0] base;
        logic [31:0] stop_at;
        logic [31:0] room;
        logic [31:0] tmp;
        logic [32:0] lim;
        logic        last;
        logic [31:0] fill[$];

        for (int k = 0; k < CAP; k++) begin
            win_present[k] = 1'b0;
        end

        // Directed rows start from the state after reset.
        add_row(OP_POP,      32'd0,         8'h00, 1'b0, 1'b1, report_of(8'h00, 0, 0, 0, 0, 0));
        add_row(OP_UNUSED,   INDEX_MAX,     8'hFF, 1'b1, 1'b1, report_of(8'h00, 0, 0, 0, 0, 0));
        add_row(OP_BYTE,     INDEX_MAX,     8'hFF, 1'b1, 1'b1, report_of(8'h00, 0, 0, 0, 0, 0));
        add_row(OP_BYTE,     32'd1024,      8'h55, 1'b0, 1'b1, report_of(8'h00, 0, 0, 0, 0, 0));
        add_row(OP_BYTE,     32'd1023,      8'hAB, 1'b0, 1'b1, report_of(8'h00, 0, 1, 0, 1, 0));
        add_row(OP_BYTE,     32'd1023,      8'h11, 1'b0, 1'b1, report_of(8'h00, 0, 1, 0, 1, 0));
        add_row(OP_BYTE,     32'd0,         8'h00, 1'b0, 1'b1, report_of(8'h00, 0, 1, 1, 1, 0));
        add_row(OP_BYTE,     32'd2,         8'hFF, 1'b0, 1'b1, report_of(8'h00, 0, 1, 1, 2, 0));
        add_row(OP_BYTE,     32'd1,         8'h5A, 1'b0, 1'b1, report_of(8'h00, 0, 1, 3, 1, 0));
        add_row(OP_BYTE,     32'd0,         8'h77, 1'b0, 1'b1, report_of(8'h00, 0, 0, 3, 1, 0));
        add_row(OP_POP,      32'd0,         8'h00, 1'b0, 1'b1, report_of(8'h00, 1, 0, 3, 1, 0));
        add_row(OP_POP,      32'd0,         8'h00, 1'b0, 1'b1, report_of(8'h5A, 1, 0, 3, 1, 0));
        add_row(OP_POP,      32'd0,         8'h00, 1'b0, 1'b1, report_of(8'hFF, 1, 0, 3, 1, 0));
        add_row(OP_POP,      32'd0,         8'h00, 1'b0, 1'b1, report_of(8'h00, 0, 0, 3, 1, 0));
        add_row(OP_END_MARK, 32'd1,         8'h00, 1'b0, 1'b1, report_of(8'h00, 0, 0, 3, 1, 0));
        add_row(OP_BYTE,     32'd0,         8'hC3, 1'b1, 1'b1, report_of(8'h00, 0, 0, 3, 1, 0));
        add_row(OP_BYTE,     32'd1026,      8'hE1, 1'b0, 1'b1, report_of(8'h00, 0, 1, 3, 2, 0));
        add_row(OP_BYTE,     32'd1027,      8'h1E, 1'b0, 1'b1, report_of(8'h00, 0, 0, 3, 2, 0));
        add_row(OP_END_MARK, INDEX_MAX,     8'h00, 1'b0, 1'b1, report_of(8'h00, 0, 0, 3, 2, 0));
        add_row(OP_BYTE,     32'd5,         8'hC3, 1'b0, 1'b0, '0);
        add_row(OP_BYTE,     32'd3,         8'h3C, 1'b0, 1'b0, '0);
        add_row(OP_BYTE,     32'd4,         8'h96, 1'b0, 1'b0, '0);
        add_row(OP_POP,      32'd0,         8'h00, 1'b0, 1'b0, '0);
        add_row(OP_BYTE,     32'h8000_0000, 8'hAA, 1'b1, 1'b0, '0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            send_item(directed_rows[k].op, directed_rows[k].idx, directed_rows[k].val,
                      directed_rows[k].last, directed_rows[k].typed, directed_rows[k].want);
        end

        n = 0;
        paused = 1'b0;
        pop_pct = 20;
        while (n < 500) begin
            if (n % 100 == 0) begin
                pop_pct = $urandom_range(5, 50);
            end
            if (n == 250 && !paused) begin
                wait_drained();
                paused = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 2) begin
                send_item(OP_UNUSED, $urandom, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'b0, '0);
            end else begin
                if (r < 2 + pop_pct) begin
                    send_item(OP_POP, $urandom, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 1'b0, '0);
                end else if (r < 8 + pop_pct) begin
                    if ($urandom_range(0, 1) && wr_ptr != 0) begin
                        idx = $urandom_range(0, wr_ptr - 1);
                    end else begin
                        idx = $urandom;
                    end
                    send_item(OP_END_MARK, clear_of_write_point(idx),
                              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
                end else begin
                    lim = {1'b0, rd_ptr} + 33'(CAP);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: idx = wr_ptr + $urandom_range(0, 15);
                        5, 6: begin
                            room = lim[31:0] - wr_ptr;
                            idx = (room == 0) ? wr_ptr : wr_ptr + $urandom_range(0, room - 1);
                        end
                        // Straddle the far edge of the window.
                        7: idx = lim[31:0] - 32'd1 + $urandom_range(0, 2);
                        8: idx = (wr_ptr >= 8) ? wr_ptr - $urandom_range(1, 8) : $urandom;
                        default: idx = $urandom;
                    endcase
                    last = ($urandom_range(0, 19) == 0);
                    if (last && (idx + 32'd1) - wr_ptr < END_GUARD) begin
                        last = 1'b0;
                    end
                    send_item(OP_BYTE, idx, 8'($urandom_range(0, 255)), last, 1'b0, '0);
                end
                n++;
            end
        end

        // Close the stream: open the whole window, fix the length, then fill
        // every gap up to it in shuffled order.
        wait_drained();
        while (rd_ptr != wr_ptr) begin
            send_item(OP_POP, $urandom, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'b0, '0);
        end
        base = wr_ptr;
        stop_at = wr_ptr + 32'd20;
        while (win_present[stop_at % CAP]) begin
            stop_at++;
        end
        send_item(OP_END_MARK, stop_at, 8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
        for (int k = 0; k < stop_at - base; k++) begin
            fill.push_back(base + k);
        end
        for (int k = fill.size() - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = fill[k];
            fill[k] = fill[j];
            fill[j] = tmp;
        end
        foreach (fill[k]) begin
            send_item(OP_BYTE, fill[k], 8'($urandom_range(0, 255)), fill[k] == stop_at - 32'd1,
                      1'b0, '0);
        end

        // Once the stream has ended, arrivals are ignored but pops still drain.
        repeat (6) begin
            send_item($urandom_range(0, 1) ? OP_BYTE : OP_END_MARK,
                      wr_ptr + $urandom_range(0, 7), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 1'b0, '0);
        end
        while (rd_ptr != wr_ptr) begin
            send_item(OP_POP, $urandom, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'b0, '0);
        end
        repeat (2) send_item(OP_POP, $urandom, 8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);

        wait_drained();
        repeat (64) @(posedge i_clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
